FILE: sv/ctgb_pkg.sv
// package for the cursor text gap buffer: command and status codes, field widths,
// and the control structs between controller and datapath; no dependencies
`timescale 1ns / 1ps

package ctgb_pkg;

  localparam int CAPACITY_DEF = 4096;

  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 12;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 13;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_LEFT   = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_BACK   = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic issue;   // request taken, stack read launched
    logic commit;  // stack write, count update, result load
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register full and stalled
  } ctl_stat_t;

endpackage

FILE: sv/ctgb_ram.sv
// generic single-write, single-read memory with registered read data
// used for both character stacks; no package dependency
`timescale 1ns / 1ps

module ctgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/ctgb_ctrl.sv
// two-state sequencer for the gap buffer: takes a request, then commits it
// depends on ctgb_pkg for state and command types
`timescale 1ns / 1ps

module ctgb_ctrl
  import ctgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.issue = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here while the previous result is still held
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/ctgb_dp.sv
// datapath of the gap buffer: two character stacks, their counts, command
// latch and result register; depends on ctgb_pkg and ctgb_ram
`timescale 1ns / 1ps

module ctgb_dp
  import ctgb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OP_W-1:0]     in_op,
  input  logic [CHAR_W-1:0]   in_char_in,
  input  logic [POS_W-1:0]    in_read_pos,
  input  ctl_cmd_t            cmd,
  output ctl_stat_t           stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [CHAR_W-1:0]   out_char_out,
  output logic [LEN_W-1:0]    out_text_length,
  output logic [LEN_W-1:0]    out_cursor_pos
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CW-1:0] left_cnt_r, right_cnt_r, left_cnt_nxt, right_cnt_nxt;
  logic [CW-1:0] total_cnt, total_nxt, left_m1, right_m1;

  op_t                op_r;
  logic [CHAR_W-1:0]  char_r;
  logic               left_side_r, range_r;

  logic [XW-1:0] pos_x, left_x, total_x, ridx_x;
  logic          in_left_side, in_range;

  logic              l_re, r_re, l_we, r_we;
  logic [AW-1:0]     l_raddr, r_raddr, l_waddr, r_waddr;
  logic [CHAR_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

  status_t           status_nxt;
  logic [CHAR_W-1:0] char_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [LEN_W-1:0]  out_len_r, out_cur_r;

  assign total_cnt = left_cnt_r + right_cnt_r;
  assign left_m1   = left_cnt_r - CW'(1);
  assign right_m1  = right_cnt_r - CW'(1);

  // position decode on the incoming request
  assign pos_x        = XW'(in_read_pos);
  assign left_x       = XW'(left_cnt_r);
  assign total_x      = XW'(total_cnt);
  assign in_left_side = pos_x < left_x;
  assign in_range     = pos_x < total_x;
  assign ridx_x       = total_x - pos_x - XW'(1);

  // read launch in the accept cycle
  always_comb begin
    l_re    = 1'b0;
    r_re    = 1'b0;
    l_raddr = left_m1[AW-1:0];
    r_raddr = right_m1[AW-1:0];
    case (op_t'(in_op))
      OP_LEFT:  l_re = cmd.issue;
      OP_RIGHT: r_re = cmd.issue;
      OP_READ: begin
        if (in_left_side) begin
          l_re    = cmd.issue;
          l_raddr = pos_x[AW-1:0];
        end else begin
          r_re    = cmd.issue;
          r_raddr = ridx_x[AW-1:0];
        end
      end
      default: begin
        l_re = 1'b0;
        r_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op_r        <= op_t'(in_op);
      char_r      <= in_char_in;
      left_side_r <= in_left_side;
      range_r     <= !in_range;
    end
  end

  // commit: stack write, count update, result
  always_comb begin
    status_nxt    = ST_DONE;
    char_nxt      = '0;
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    l_we          = 1'b0;
    r_we          = 1'b0;
    l_waddr       = left_cnt_r[AW-1:0];
    r_waddr       = right_cnt_r[AW-1:0];
    l_wdata       = char_r;
    r_wdata       = l_rdata;
    case (op_r)
      OP_INSERT: begin
        if (total_cnt >= CW'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          l_we         = cmd.commit;
          left_cnt_nxt = left_cnt_r + CW'(1);
        end
      end
      OP_LEFT: begin
        if (left_cnt_r == '0) begin
          status_nxt = ST_IGNORED;
        end else begin
          r_we          = cmd.commit;
          left_cnt_nxt  = left_m1;
          right_cnt_nxt = right_cnt_r + CW'(1);
        end
      end
      OP_RIGHT: begin
        if (right_cnt_r == '0) begin
          status_nxt = ST_IGNORED;
        end else begin
          l_we          = cmd.commit;
          l_wdata       = r_rdata;
          right_cnt_nxt = right_m1;
          left_cnt_nxt  = left_cnt_r + CW'(1);
        end
      end
      OP_BACK: begin
        if (left_cnt_r == '0) begin
          status_nxt = ST_IGNORED;
        end else begin
          left_cnt_nxt = left_m1;
        end
      end
      OP_READ: begin
        if (range_r) begin
          status_nxt = ST_RANGE;
        end else begin
          char_nxt = left_side_r ? l_rdata : r_rdata;
        end
      end
      default: status_nxt = ST_IGNORED;
    endcase
  end

  assign total_nxt = left_cnt_nxt + right_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        left_cnt_r  <= left_cnt_nxt;
        right_cnt_r <= right_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_char_r   <= char_nxt;
      out_len_r    <= LEN_W'(total_nxt);
      out_cur_r    <= LEN_W'(left_cnt_nxt);
    end
  end

  ctgb_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  ctgb_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  assign stat.out_busy   = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_char_out    = out_char_r;
  assign out_text_length = out_len_r;
  assign out_cursor_pos  = out_cur_r;

endmodule

FILE: sv/cursor_text_gap_buffer.sv
// cursor text gap buffer top level: a request is taken in the idle state and its result is
// registered at commit; one request at a time, since the stack ram read (accept cycle) is
// followed by the dependent write and count update (commit cycle)
// commit waits while a previous result is stalled on the output
// synchronous active-low reset clears the counts, sequencer and result valid;
// stack memories are not cleared and hold nothing meaningful until written
`timescale 1ns / 1ps

module cursor_text_gap_buffer
  import ctgb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [CHAR_W-1:0]   in_char_in,
  input  logic [POS_W-1:0]    in_read_pos,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [CHAR_W-1:0]   out_char_out,
  output logic [LEN_W-1:0]    out_text_length,
  output logic [LEN_W-1:0]    out_cursor_pos
);

  // command and status between sequencer and datapath
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer: idle takes a request and launches the stack read,
  // exec commits once the result register is free
  ctgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: left stack in text order, right stack reversed so its top
  // is the character just right of the cursor
  ctgb_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_char_in      (in_char_in),
    .in_read_pos     (in_read_pos),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_char_out    (out_char_out),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos)
  );

endmodule

FILE: sv/ctgb_checker.sv
// port-level checker for the cursor text gap buffer, bound to the top level
// depends on ctgb_pkg for the status codes
`timescale 1ns / 1ps

module ctgb_checker
  import ctgb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [CHAR_W-1:0]   out_char_out,
  input logic [LEN_W-1:0]    out_text_length,
  input logic [LEN_W-1:0]    out_cursor_pos
);

  // one request at a time: a taken request blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  // only a successful read carries a character
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_char_out == '0))
    else $error("character on a result that is not a read");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_char_out) && $stable(out_text_length) && $stable(out_cursor_pos)))
    else $error("stalled result changed");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cursor_text_gap_buffer ctgb_checker u_ctgb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_char_out    (out_char_out),
  .out_text_length (out_text_length),
  .out_cursor_pos  (out_cursor_pos)
);

FILE: tb/testbench.sv
// self-checking bench for cursor_text_gap_buffer: directed script, mixed random edits,
// then a short tail of edits and far reads; depends on ctgb_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import ctgb_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEF;
  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_ITEMS   = 1470;
  localparam int LONG_HOLD      = 240;   // cycles the result side refuses during the long hold
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 8;     // leave room after the drain for stray results
  localparam int MAX_REPORTS    = 10;

  // op codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  // command letters of the classic editor exercise, used as text bytes
  localparam logic [CHAR_W-1:0] CH_L = "L";
  localparam logic [CHAR_W-1:0] CH_D = "D";
  localparam logic [CHAR_W-1:0] CH_B = "B";
  localparam logic [CHAR_W-1:0] CH_P = "P";

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
  } edit_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   chr;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    cur;
  } edit_result_t;

  // typed rows carry their own expected result, the rest use the predictor
  typedef struct packed {
    logic         typed;
    edit_cmd_t    cmd;
    edit_result_t want;
  } script_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_op;
  logic [CHAR_W-1:0]   in_char_in;
  logic [POS_W-1:0]    in_read_pos;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [CHAR_W-1:0]   out_char_out;
  logic [LEN_W-1:0]    out_text_length;
  logic [LEN_W-1:0]    out_cursor_pos;

  cursor_text_gap_buffer #(.CAPACITY(CAPACITY)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_char_in      (in_char_in),
    .in_read_pos     (in_read_pos),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_char_out    (out_char_out),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos)
  );

  // after reset: boundary moves, reads on an empty text, spare ops, then a short text built
  // from the byte extremes and the command letters, read back, moved over and edited
  script_row_t directed_script [DIRECTED_ROWS] = '{
    '{1'b1, '{OP_LEFT,      8'h00, 12'h000}, '{ST_IGNORED, 8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_RIGHT,     8'hff, 12'hfff}, '{ST_IGNORED, 8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_BACK,      8'h00, 12'h000}, '{ST_IGNORED, 8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_READ,      8'h00, 12'h000}, '{ST_RANGE,   8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_READ,      8'hff, 12'hfff}, '{ST_RANGE,   8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_SPARE_LO,  8'h00, 12'h000}, '{ST_IGNORED, 8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_SPARE_HI,  8'hff, 12'hfff}, '{ST_IGNORED, 8'h00, 13'd0, 13'd0}},
    '{1'b1, '{OP_INSERT,    8'h00, 12'hfff}, '{ST_DONE,    8'h00, 13'd1, 13'd1}},
    '{1'b1, '{OP_INSERT,    8'hff, 12'h000}, '{ST_DONE,    8'h00, 13'd2, 13'd2}},
    '{1'b1, '{OP_INSERT,    CH_L,  12'h000}, '{ST_DONE,    8'h00, 13'd3, 13'd3}},
    '{1'b1, '{OP_INSERT,    CH_D,  12'h000}, '{ST_DONE,    8'h00, 13'd4, 13'd4}},
    '{1'b1, '{OP_INSERT,    CH_B,  12'h000}, '{ST_DONE,    8'h00, 13'd5, 13'd5}},
    '{1'b1, '{OP_INSERT,    CH_P,  12'h000}, '{ST_DONE,    8'h00, 13'd6, 13'd6}},
    '{1'b1, '{OP_READ,      8'h00, 12'd0},   '{ST_DONE,    8'h00, 13'd6, 13'd6}},
    '{1'b1, '{OP_READ,      8'h00, 12'd1},   '{ST_DONE,    8'hff, 13'd6, 13'd6}},
    '{1'b1, '{OP_READ,      8'h00, 12'd5},   '{ST_DONE,    CH_P,  13'd6, 13'd6}},
    '{1'b1, '{OP_READ,      8'h00, 12'd6},   '{ST_RANGE,   8'h00, 13'd6, 13'd6}},
    '{1'b1, '{OP_LEFT,      8'h00, 12'h000}, '{ST_DONE,    8'h00, 13'd6, 13'd5}},
    '{1'b1, '{OP_READ,      8'h00, 12'd5},   '{ST_DONE,    CH_P,  13'd6, 13'd5}},
    '{1'b1, '{OP_RIGHT,     8'h00, 12'h000}, '{ST_DONE,    8'h00, 13'd6, 13'd6}},
    '{1'b1, '{OP_RIGHT,     8'h00, 12'h000}, '{ST_IGNORED, 8'h00, 13'd6, 13'd6}},
    '{1'b0, '{OP_LEFT,      8'h5a, 12'h000}, '0},
    '{1'b0, '{OP_BACK,      8'ha5, 12'h000}, '0},
    '{1'b0, '{OP_READ,      8'h00, 12'd3},   '0},
    '{1'b0, '{OP_SPARE_MID, 8'h00, 12'h000}, '0}
  };

  // predictor state: the two stacks and their fill levels
  logic [CHAR_W-1:0] left_mem  [CAPACITY];
  logic [CHAR_W-1:0] right_mem [CAPACITY];
  int                left_len;
  int                right_len;

  edit_result_t results_due [$];   // one per accepted request, oldest first

  int  requests_sent;
  int  reads_sent;
  int  peak_length;
  int  results_seen;
  int  status_seen [4];
  int  mismatches;
  int  long_holds;
  int  quiet_cycles;
  bit  sender_steady;   // set: requests back to back, no gaps
  bit  long_hold_req;   // raised by the request side, served by the result side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predictor: applies one command to the local copy of the text
  // -------------------------------------------------------------------------
  function automatic edit_result_t apply_edit(input edit_cmd_t c);
    edit_result_t r;
    int           pos_i;
    r        = '0;
    r.status = ST_DONE;
    pos_i    = int'(c.pos);
    case (c.op)
      OP_INSERT: begin
        if (left_len + right_len >= CAPACITY) begin
          r.status = ST_FULL;   // character dropped
        end else begin
          left_mem[left_len] = c.ch;
          left_len++;
        end
      end
      OP_LEFT: begin
        if (left_len == 0) begin
          r.status = ST_IGNORED;
        end else begin
          // character crosses the cursor onto the right stack
          left_len--;
          right_mem[right_len] = left_mem[left_len];
          right_len++;
        end
      end
      OP_RIGHT: begin
        if (right_len == 0) begin
          r.status = ST_IGNORED;
        end else begin
          right_len--;
          left_mem[left_len] = right_mem[right_len];
          left_len++;
        end
      end
      OP_BACK: begin
        if (left_len == 0) r.status = ST_IGNORED;
        else left_len--;
      end
      OP_READ: begin
        reads_sent++;
        if (pos_i < left_len) begin
          r.chr = left_mem[pos_i];
        end else if (pos_i - left_len < right_len) begin
          // right stack is stored reversed, its top sits next to the cursor
          r.chr = right_mem[right_len - 1 - (pos_i - left_len)];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    if (left_len + right_len > peak_length) peak_length = left_len + right_len;
    r.len = LEN_W'(left_len + right_len);
    r.cur = LEN_W'(left_len);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    // mostly printable text, sometimes any byte
    if ($urandom_range(3) != 0) return CHAR_W'($urandom_range(126, 32));
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(4095));
  endfunction

  // -------------------------------------------------------------------------
  // request side: entered and left at a falling edge
  // -------------------------------------------------------------------------
  task automatic offer_request(input edit_cmd_t c, input bit typed, input edit_result_t want);
    int           gap;
    edit_result_t predicted;
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = c.op;
    in_char_in  = c.ch;
    in_read_pos = c.pos;
    // hold the request until the block takes it
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = apply_edit(c);
    results_due.push_back(typed ? want : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    edit_cmd_t c;
    c.op  = op;
    c.ch  = ch;
    c.pos = pos;
    offer_request(c, 1'b0, '0);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input edit_result_t want,
                                 input edit_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: want status %0d char %h len %0d cursor %0d, %s %0d %s %h %s %0d %s %0d",
               $time, what, want.status, want.chr, want.len, want.cur,
               "got status", got.status, "char", got.chr, "len", got.len,
               "cursor", got.cur);
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin : request_source
    int              kind;
    int              n;
    int              text_len;
    int              roll;
    int              p;
    bit              hold_issued;
    logic [OP_W-1:0] dir;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_INSERT;
    in_char_in    = '0;
    in_read_pos   = '0;
    sender_steady = 1'b0;
    long_hold_req = 1'b0;
    hold_issued   = 1'b0;
    left_len      = 0;
    right_len     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed script
    for (int i = 0; i < DIRECTED_ROWS; i++)
      offer_request(directed_script[i].cmd, directed_script[i].typed, directed_script[i].want);
    drain_results();

    // mixed editing: bursts of typing, cursor walks, deletes and reads
    while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      kind          = $urandom_range(99);
      text_len      = left_len + right_len;
      sender_steady = ($urandom_range(3) == 0);
      if (!hold_issued && requests_sent >= 400) begin
        // long output hold while requests keep coming back to back
        hold_issued   = 1'b1;
        long_hold_req = 1'b1;
        sender_steady = 1'b1;
      end
      // keep the text short so walks to the ends stay cheap
      if (text_len > 200 && kind < 28) kind = 50;

      if (kind < 28) begin
        n = $urandom_range(12, 1);
        repeat (n) send_edit(OP_INSERT, rand_char(), rand_pos());
      end else if (kind < 40) begin
        dir = $urandom_range(1) ? OP_LEFT : OP_RIGHT;
        n   = $urandom_range(8, 1);
        repeat (n) send_edit(dir, rand_char(), rand_pos());
      end else if (kind < 46) begin
        // home or end, then one more move that must be ignored
        if ($urandom_range(1)) begin
          while (left_len > 0) send_edit(OP_LEFT, rand_char(), rand_pos());
          send_edit(OP_LEFT, rand_char(), rand_pos());
        end else begin
          while (right_len > 0) send_edit(OP_RIGHT, rand_char(), rand_pos());
          send_edit(OP_RIGHT, rand_char(), rand_pos());
        end
      end else if (kind < 56) begin
        n = (text_len > 200) ? $urandom_range(60, 30) : $urandom_range(6, 1);
        repeat (n) send_edit(OP_BACK, rand_char(), rand_pos());
      end else if (kind < 78) begin
        n = $urandom_range(8, 1);
        repeat (n) begin
          text_len = left_len + right_len;
          roll     = $urandom_range(9);
          if (roll < 7)
            send_edit(OP_READ, rand_char(),
                      POS_W'(text_len == 0 ? 0 : $urandom_range(text_len - 1)));
          else if (roll < 9)
            send_edit(OP_READ, rand_char(), POS_W'(text_len + $urandom_range(2)));
          else
            send_edit(OP_READ, rand_char(), rand_pos());
        end
      end else if (kind < 84) begin
        // read the text back in order, up to 80 positions, one past the end too if it fits
        for (p = 0; p <= text_len && p < 80; p++) send_edit(OP_READ, rand_char(), POS_W'(p));
      end else if (kind < 97) begin
        n = $urandom_range(4, 1);
        repeat (n) send_edit(OP_W'($urandom_range(OP_SPARE_HI)), CHAR_W'($urandom_range(255)),
                             rand_pos());
      end else begin
        drain_results();
      end
    end
    drain_results();

    // tail: inserts, reads at the top positions, moves around the cursor, spare ops
    sender_steady = 1'b0;
    repeat (3) send_edit(OP_INSERT, rand_char(), rand_pos());
    send_edit(OP_READ, rand_char(), POS_W'(CAPACITY - 1));
    send_edit(OP_READ, rand_char(), POS_W'(CAPACITY - 2));
    send_edit(OP_READ, rand_char(), '0);
    repeat (20) send_edit(OP_READ, rand_char(), rand_pos());
    send_edit(OP_LEFT, rand_char(), rand_pos());
    send_edit(OP_INSERT, rand_char(), rand_pos());
    send_edit(OP_RIGHT, rand_char(), rand_pos());
    send_edit(OP_RIGHT, rand_char(), rand_pos());
    send_edit(OP_BACK, rand_char(), rand_pos());
    send_edit(OP_INSERT, rand_char(), rand_pos());
    send_edit(OP_INSERT, rand_char(), rand_pos());
    send_edit(OP_READ, rand_char(), POS_W'(CAPACITY - 1));
    send_edit(OP_SPARE_LO, rand_char(), rand_pos());
    send_edit(OP_SPARE_MID, rand_char(), rand_pos());
    send_edit(OP_SPARE_HI, rand_char(), rand_pos());
    repeat (10) send_edit(OP_READ, rand_char(), rand_pos());

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d reads, text up to %0d of %0d chars",
             requests_sent, results_seen, reads_sent, peak_length, CAPACITY);
    $display("results: %0d done, %0d ignored, %0d dropped, %0d out of range; %0d long hold",
             status_seen[ST_DONE], status_seen[ST_IGNORED], status_seen[ST_FULL],
             status_seen[ST_RANGE], long_holds);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // result side: random stall runs, long open stretches, one long hold
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int run_left;
    bit holding;
    out_stall  = 1'b0;
    run_left   = 0;
    holding    = 1'b0;
    long_holds = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // the block fills up and must stall its request side
        long_hold_req = 1'b0;
        out_stall     = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_holds++;
        out_stall = 1'b0;
        holding   = 1'b0;
        run_left  = 8;
      end else if (run_left != 0) begin
        run_left--;
      end else begin
        if (holding) begin
          holding  = 1'b0;
          run_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(15, 1);
        end else begin
          run_left = pick_gap();
          holding  = (run_left != 0);
        end
        out_stall = holding;
      end
    end
  end

  // -------------------------------------------------------------------------
  // result check against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    edit_result_t got;
    edit_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_char_out, out_text_length, out_cursor_pos};
      if (results_due.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, got);
      end else begin
        want = results_due.pop_front();
        results_seen++;
        if (got.status !== want.status || got.chr !== want.chr ||
            got.len !== want.len || got.cur !== want.cur)
          report_mismatch("result differs", want, got);
        else
          status_seen[got.status]++;
      end
    end
  end

  // watchdog: ends the run when neither side has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d results outstanding",
                 quiet_cycles, results_due.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
